### rtl/fmpx_pkg.sv
// ----------------------------------------------------------------------------
// fmpx_pkg: shared types and constants for the min-priority extract queue
// Field widths, operation and status codes, and the beat and cell types.
// ----------------------------------------------------------------------------
`default_nettype none

package fmpx_pkg;

	// Queue depth and derived widths.
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Fixed field widths.
	localparam int OP_W   = 2;
	localparam int ID_W   = 16;
	localparam int PRIO_W = 16;
	localparam int ST_W   = 2;
	localparam int OCC_W  = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
	localparam logic [OP_W-1:0] OP_POP     = 2'd1;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd2;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Request beat.
	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [ID_W-1:0]          proc_id;
		logic signed [PRIO_W-1:0] prio;
	} req_t;

	// Response beat.
	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic [ID_W-1:0]          out_id;
		logic signed [PRIO_W-1:0] out_prio;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	// One stored queue entry.
	typedef struct packed {
		logic [ID_W-1:0]          id;
		logic signed [PRIO_W-1:0] prio;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic load;
		logic shift;
		logic occ;
	} cell_ctrl_t;

	// Minimum-search token handed from cell to cell.
	typedef struct packed {
		logic   vld;
		logic   have;
		idx_t   pos;
		entry_t ent;
	} scan_t;

endpackage

`default_nettype wire

### rtl/fmpx_cell.sv
// ----------------------------------------------------------------------------
// fmpx_cell: one queue slot
// Holds one entry, loads a pushed entry or its upper neighbor on compaction,
// and passes the running-minimum token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpx_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  fmpx_pkg::cell_ctrl_t ctrl,
	input  fmpx_pkg::idx_t      idx,
	input  fmpx_pkg::entry_t    push_entry,
	input  fmpx_pkg::entry_t    next_entry,
	output fmpx_pkg::entry_t    entry,
	input  fmpx_pkg::scan_t     scan_in,
	output fmpx_pkg::scan_t     scan_out
);
	import fmpx_pkg::*;

	entry_t entry_q;
	logic   scan_vld_q;
	logic   scan_have_q;
	idx_t   scan_pos_q;
	entry_t scan_ent_q;
	logic   take;

	// Stored entry: a push writes the tail slot, a removal shifts down.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			entry_q <= push_entry;
		end else if (ctrl.shift) begin
			entry_q <= next_entry;
		end
	end

	// This cell becomes the best so far when occupied and strictly smaller,
	// so the earliest entry wins a tie.
	assign take = scan_in.vld && ctrl.occ &&
		(!scan_in.have || ($signed(entry_q.prio) < $signed(scan_in.ent.prio)));

	// Token valid travels one cell per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_q <= 1'b0;
		end else begin
			scan_vld_q <= scan_in.vld;
		end
	end

	// Token payload.
	always_ff @(posedge clk) begin
		if (take) begin
			scan_have_q <= 1'b1;
			scan_pos_q  <= idx;
			scan_ent_q  <= entry_q;
		end else begin
			scan_have_q <= scan_in.have;
			scan_pos_q  <= scan_in.pos;
			scan_ent_q  <= scan_in.ent;
		end
	end

	assign entry        = entry_q;
	assign scan_out.vld  = scan_vld_q;
	assign scan_out.have = scan_have_q;
	assign scan_out.pos  = scan_pos_q;
	assign scan_out.ent  = scan_ent_q;

endmodule

`default_nettype wire

### rtl/fifo_with_min_priority_extract.sv
// Push, pop and the unused code go from the request register to the commit state and then the
// response register. Extract on a non-empty queue first walks the minimum token through the cell
// chain one cell per cycle. One item is in work at a time; a held response adds its wait.
// Reset clears the fill count and all control state; entries need no clearing.
// ----------------------------------------------------------------------------
// fifo_with_min_priority_extract: arrival-order queue with min-priority extract
// A row of cells keeps entries in arrival order. Push appends at the tail,
// pop removes the head, extract removes the lowest priority (earliest on
// ties) and the cells above it shift down to close the gap.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_min_priority_extract (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  fmpx_pkg::req_t  req,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output fmpx_pkg::rsp_t  rsp
);
	import fmpx_pkg::*;

	// Sequencer states.
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	req_t       req_q;
	cnt_t       count_q;
	idx_t       pos_q;
	entry_t     rm_ent_q;
	logic       start_q;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	cell_ctrl_t ctrl [DEPTH];
	entry_t     ent  [DEPTH];
	entry_t     nxt  [DEPTH];
	scan_t      scan [DEPTH+1];

	logic   accept;
	logic   commit;
	logic   full;
	logic   empty;
	logic   is_push;
	logic   is_rm;
	logic   do_push;
	logic   do_rm;
	cnt_t   count_nxt;
	entry_t sel_ent;
	entry_t push_ent;

	// Request handshake: one item in work at a time.
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	// Commit decode; waits while an earlier response is still held.
	assign commit  = (state_q == S_COMMIT) && (!rsp_valid_q || !rsp_stall);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign is_push = (req_q.op == OP_PUSH);
	assign is_rm   = (req_q.op == OP_POP) || (req_q.op == OP_EXTRACT);
	assign do_push = commit && is_push && !full;
	assign do_rm   = commit && is_rm && !empty;
	assign sel_ent = (req_q.op == OP_EXTRACT) ? rm_ent_q : ent[0];

	assign push_ent.id   = req_q.proc_id;
	assign push_ent.prio = req_q.prio;

	always_comb begin
		count_nxt = count_q;
		if (do_push) begin
			count_nxt = count_q + 1'b1;
		end else if (do_rm) begin
			count_nxt = count_q - 1'b1;
		end
	end

	// Search token entering the first cell.
	assign scan[0].vld  = start_q;
	assign scan[0].have = 1'b0;
	assign scan[0].pos  = '0;
	assign scan[0].ent  = '0;

	// Cell chain.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign ctrl[g].occ   = (CNT_W'(g) < count_q);
		assign ctrl[g].load  = do_push && (CNT_W'(g) == count_q);
		assign ctrl[g].shift = do_rm && (IDX_W'(g) >= pos_q);

		if (g == DEPTH - 1) begin : g_last
			assign nxt[g] = ent[g];
		end else begin : g_mid
			assign nxt[g] = ent[g+1];
		end

		fmpx_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[g]),
			.idx        (IDX_W'(g)),
			.push_entry (push_ent),
			.next_entry (nxt[g]),
			.entry      (ent[g]),
			.scan_in    (scan[g]),
			.scan_out   (scan[g+1])
		);
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((req.op == OP_EXTRACT) && !empty) begin
							state_q <= S_SCAN;
							start_q <= 1'b1;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_SCAN: begin
					if (scan[DEPTH].vld) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit) begin
						state_q <= S_IDLE;
						count_q <= count_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture and search result.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			pos_q <= '0;
		end else if ((state_q == S_SCAN) && scan[DEPTH].vld) begin
			pos_q    <= scan[DEPTH].pos;
			rm_ent_q <= scan[DEPTH].ent;
		end
	end

	// Response register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q.occupancy <= OCC_W'(count_nxt);
			rsp_q.out_id    <= '0;
			rsp_q.out_prio  <= '0;
			if (is_push && full) begin
				rsp_q.status <= ST_FULL;
			end else if (is_rm && empty) begin
				rsp_q.status <= ST_EMPTY;
			end else begin
				rsp_q.status <= ST_OK;
				if (is_rm) begin
					rsp_q.out_id   <= sel_ent.id;
					rsp_q.out_prio <= sel_ent.prio;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### rtl/fmpx_chk.sv
// ----------------------------------------------------------------------------
// fmpx_chk: port-level checks for the min-priority extract queue
// Watches the request and response beats and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fmpx_chk (
	input wire            clk,
	input wire            arst_n,
	input wire            req_valid,
	input wire            req_stall,
	input wire            rsp_valid,
	input wire            rsp_stall,
	input fmpx_pkg::rsp_t rsp
);
	import fmpx_pkg::*;

	// A held response beat keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("held response beat changed");

	// Only one item is in work: the cycle after a request beat is stalled.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while an item is in work");

	// A full status reports a full queue.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(DEPTH)))
		else $error("full status with queue not full");

	// An empty status reports an empty queue and no entry.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |->
			(rsp.occupancy == '0) && (rsp.out_id == '0) && (rsp.out_prio == '0))
		else $error("empty status with entries or data");

endmodule

bind fifo_with_min_priority_extract fmpx_chk u_fmpx_chk (.*);

`default_nettype wire

### sim/fifo_with_min_priority_extract_test.sv
// ----------------------------------------------------------------------------
// fifo_with_min_priority_extract_test: self-checking bench for the extract queue
// Drives push, pop, extract and unused-code beats with random idling and
// back-pressure. A queue model predicts each response beat, and a checker
// compares every accepted response beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_with_min_priority_extract_test;

	timeunit 1ns;
	timeprecision 1ps;

	import fmpx_pkg::*;

	// The spare selector value, which the block answers without touching the queue.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int IDLE_PCT       = 36;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = DEPTH + 3 + 8;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Queue model and the response beats it has predicted.
	entry_t held_entries[$];
	rsp_t   expected_rsps[$];

	// Idling control shared by both sides, and the long-hold request.
	bit idle_enabled = 1'b1;
	int hold_trigger = 0;
	int hold_served  = 0;
	int hold_left    = 0;

	// Run statistics.
	int error_count  = 0;
	int rsp_checked  = 0;
	int op_seen[4]   = '{0, 0, 0, 0};
	int full_seen    = 0;
	int empty_seen   = 0;
	int quiet_cycles = 0;

	fifo_with_min_priority_extract i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the queue model and returns the response it must produce.
	function automatic rsp_t predict_queue_op(req_t item);
		rsp_t   result;
		entry_t fresh;
		int     pos;
		result = '0;
		result.status = ST_OK;
		case (item.op)
			OP_PUSH: begin
				if (held_entries.size() >= DEPTH) begin
					result.status = ST_FULL;
				end else begin
					fresh.id = item.proc_id;
					fresh.prio = item.prio;
					held_entries.push_back(fresh);
				end
			end
			OP_POP, OP_EXTRACT: begin
				if (held_entries.size() == 0) begin
					result.status = ST_EMPTY;
				end else begin
					pos = 0;
					// Strictly lower wins, so the earliest entry is kept on a tie.
					if (item.op == OP_EXTRACT) begin
						for (int i = 1; i < held_entries.size(); i++) begin
							if (held_entries[i].prio < held_entries[pos].prio) begin
								pos = i;
							end
						end
					end
					result.out_id = held_entries[pos].id;
					result.out_prio = held_entries[pos].prio;
					held_entries.delete(pos);
				end
			end
			default: begin
			end
		endcase
		result.occupancy = OCC_W'(held_entries.size());
		return result;
	endfunction

	function automatic req_t make_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [PRIO_W-1:0] prio);
		req_t item;
		item.op = op;
		item.proc_id = id;
		item.prio = prio;
		return item;
	endfunction

	// Random request; id and priority are random even where the block ignores them.
	function automatic req_t random_request(int push_pct);
		req_t              item;
		int                roll;
		logic [PRIO_W-1:0] pick;
		roll = $urandom_range(99);
		if (roll < push_pct) begin
			item.op = OP_PUSH;
		end else if (roll < push_pct + 4) begin
			item.op = OP_UNUSED;
		end else if ($urandom_range(2) == 0) begin
			item.op = OP_POP;
		end else begin
			item.op = OP_EXTRACT;
		end
		item.proc_id = ID_W'($urandom);
		// A narrow band of priorities makes ties common.
		case ($urandom_range(3))
			1: begin
				pick = PRIO_W'($urandom_range(6)) - PRIO_W'(3);
			end
			2: begin
				pick = $urandom_range(1) ? 16'h8000 : 16'h7fff;
			end
			default: begin
				pick = PRIO_W'($urandom);
			end
		endcase
		item.prio = pick;
		return item;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, field, got, want);
		error_count++;
	endtask

	// Sends one request beat. Valid is only lowered for an idle gap, so a
	// back-to-back beat never sees valid dropped and raised in one step.
	task automatic send_request(req_t item);
		int   gap;
		rsp_t prediction;
		gap = 0;
		while (idle_enabled && $urandom_range(99) < IDLE_PCT) begin
			gap++;
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do begin
			@(posedge clk);
		end while (req_stall);
		prediction = predict_queue_op(item);
		expected_rsps.push_back(prediction);
		op_seen[item.op]++;
		if (prediction.status == ST_FULL) begin
			full_seen++;
		end
		if (prediction.status == ST_EMPTY) begin
			empty_seen++;
		end
	endtask

	// Stops offering beats and waits until every predicted response has arrived.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsps.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Removals and the unused code on an empty queue.
	task automatic test_empty_queue();
		send_request(make_request(OP_POP, 16'h1234, 16'h0001));
		send_request(make_request(OP_EXTRACT, 16'hffff, 16'h8000));
		send_request(make_request(OP_UNUSED, 16'hffff, 16'h7fff));
	endtask

	// Fills the queue with extreme ids and priorities, then pushes once more into a full queue.
	task automatic test_fill_and_overflow();
		int fill_prios[16] = '{100, -5, 32767, 0, -32768, 7, -1, 32767,
			-32768, 5, 0, 1, -2, 3, 4, 2};
		logic [ID_W-1:0] id;
		for (int i = 0; i < 16; i++) begin
			case (i)
				0: id = 16'hffff;
				1: id = 16'h0000;
				2: id = 16'ha5a5;
				3: id = 16'h5a5a;
				default: id = ID_W'(16'h1000 + i);
			endcase
			send_request(make_request(OP_PUSH, id, PRIO_W'(fill_prios[i])));
		end
		send_request(make_request(OP_PUSH, 16'hbeef, 16'h0001));
	endtask

	// Extracts two tied minimums in arrival order, pops the head, reads the count.
	task automatic test_extract_order();
		send_request(make_request(OP_EXTRACT, 16'h0000, 16'h0000));
		send_request(make_request(OP_EXTRACT, 16'hffff, 16'hffff));
		send_request(make_request(OP_POP, 16'h0000, 16'h0000));
		send_request(make_request(OP_UNUSED, 16'h0000, 16'h0000));
	endtask

	// Random traffic in phases that push the fill level toward full and toward empty.
	task automatic test_random_traffic(int beats);
		int push_pct;
		push_pct = 50;
		for (int n = 0; n < beats; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 85;
					1: push_pct = 50;
					default: push_pct = 20;
				endcase
			end
			send_request(random_request(push_pct));
		end
	endtask

	// A stretch with no idling on either side.
	task automatic test_no_idle(int beats);
		idle_enabled = 1'b0;
		test_random_traffic(beats);
		idle_enabled = 1'b1;
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering beats.
	task automatic test_backpressure(int beats);
		hold_trigger++;
		for (int n = 0; n < beats; n++) begin
			send_request(random_request(70));
		end
	endtask

	// The sender pauses until every response has come back, several times over.
	task automatic test_pause_until_drained(int rounds, int beats);
		for (int r = 0; r < rounds; r++) begin
			test_random_traffic(beats);
			wait_for_drain();
		end
	endtask

	// Receiver: random stalls, or a long hold when one is requested.
	always @(posedge clk) begin
		if (hold_trigger != hold_served) begin
			hold_served = hold_trigger;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= idle_enabled && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Checks each accepted response beat against the oldest prediction.
	always @(posedge clk) begin : check_response
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected response beat", 32'(rsp), 32'd0);
			end else begin
				want = expected_rsps.pop_front();
				rsp_checked++;
				if (rsp.status !== want.status) begin
					report_mismatch("status", 32'(rsp.status), 32'(want.status));
				end
				if (rsp.out_id !== want.out_id) begin
					report_mismatch("out_id", 32'(rsp.out_id), 32'(want.out_id));
				end
				if (rsp.out_prio !== want.out_prio) begin
					report_mismatch("out_prio", 32'(rsp.out_prio), 32'(want.out_prio));
				end
				if (rsp.occupancy !== want.occupancy) begin
					report_mismatch("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no beat on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: no beat accepted for %0d cycles", $time, quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_fill_and_overflow();
		test_extract_order();
		test_random_traffic(1300);
		test_no_idle(200);
		test_backpressure(60);
		test_pause_until_drained(6, 20);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d response beats: %0d push, %0d pop, %0d extract, %0d unused code.",
			rsp_checked, op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_EXTRACT],
			op_seen[OP_UNUSED]);
		$display("Pushes into a full queue: %0d, removals from an empty queue: %0d.",
			full_seen, empty_seen);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/fmpx_pkg.sv
rtl/fmpx_cell.sv
rtl/fifo_with_min_priority_extract.sv
rtl/fmpx_chk.sv
sim/fifo_with_min_priority_extract_test.sv
